// File: rtl/ssbfs_pkg.sv
// Shared types, sizes and helpers for the stereo six-band FIR splitter.
// No dependencies; every other file in rtl/ imports this package.
package ssbfs_pkg;

  // Data format and filter geometry
  localparam int TAPS    = 64;
  localparam int SW      = 24;                 // sample width, Q1.(SW-1)
  localparam int FRAC    = SW - 1;
  localparam int PW      = 2 * SW;             // full product width
  localparam int ACC_W   = 48;                 // accumulator with guard bits
  localparam int NFILT   = 6;
  localparam int NTAB    = 3;
  localparam int CIDX_W  = 6;                  // coefficient index field width
  localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DL_DEPTH = NFILT * TAPS;
  localparam int CF_DEPTH = NTAB * TAPS;
  localparam int DL_AW   = $clog2(DL_DEPTH);
  localparam int CF_AW   = $clog2(CF_DEPTH);

  localparam logic [SW-1:0] SMAX_V = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN_V = {1'b1, {(SW-1){1'b0}}};

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Coefficient table codes
  localparam logic [1:0] TBL_LP = 2'd0;
  localparam logic [1:0] TBL_HP = 2'd1;
  localparam logic [1:0] TBL_BP = 2'd2;

  // Result slots: gains and the six filter outputs
  localparam logic [2:0] SLOT_GL  = 3'd0;
  localparam logic [2:0] SLOT_LPL = 3'd1;
  localparam logic [2:0] SLOT_HPL = 3'd2;
  localparam logic [2:0] SLOT_BPL = 3'd3;
  localparam logic [2:0] SLOT_BPR = 3'd4;
  localparam logic [2:0] SLOT_HPR = 3'd5;
  localparam logic [2:0] SLOT_LPR = 3'd6;
  localparam logic [2:0] SLOT_GR  = 3'd7;

  // One operation issued to the shared multiply-accumulate unit
  typedef struct packed {
    logic       valid;
    logic       first;   // clear the accumulator
    logic       last;    // deliver the saturated sum
    logic       bypass;  // newest sample taken from the register, not memory
    logic       gain;    // operands are pre-gain and an input sample
    logic [2:0] slot;
  } op_t;

  // Memory port requests from the sequencer
  typedef struct packed {
    logic             dl_we;
    logic [DL_AW-1:0] dl_waddr;
    logic [SW-1:0]    dl_wdata;
    logic [DL_AW-1:0] dl_raddr;
    logic             cf_we;
    logic [CF_AW-1:0] cf_waddr;
    logic [SW-1:0]    cf_wdata;
    logic [CF_AW-1:0] cf_raddr;
  } mem_req_t;

  // Finished sum from the accumulate unit
  typedef struct packed {
    logic          valid;
    logic [2:0]    slot;
    logic [SW-1:0] data;
  } res_t;

  // Coefficient table used by each filter
  function automatic logic [1:0] filt_table(logic [2:0] f);
    logic [1:0] t;
    case (f)
      3'd0:    t = TBL_LP;
      3'd1:    t = TBL_HP;
      3'd2:    t = TBL_BP;
      3'd3:    t = TBL_BP;
      3'd4:    t = TBL_HP;
      default: t = TBL_LP;
    endcase
    return t;
  endfunction

  function automatic logic [DL_AW-1:0] dl_addr(logic [2:0] f, logic [TAP_W-1:0] i);
    return DL_AW'(f) * DL_AW'(TAPS) + DL_AW'(i);
  endfunction

  function automatic logic [CF_AW-1:0] cf_addr(logic [1:0] t, logic [TAP_W-1:0] k);
    return CF_AW'(t) * CF_AW'(TAPS) + CF_AW'(k);
  endfunction

endpackage

// File: rtl/stereo_six_band_fir_splitter.sv
// Stereo six-band FIR splitter: pre-gain and six 64-tap FIR filters on one shared MAC.
// Sample item: the gain steps, then six tap walks of TAPS taps at one tap per cycle; the next
// item is taken only after the result has been loaded into the output register.
// Coefficient-write item: taken while idle, no result. After reset the block clears the
// delay lines and coefficient tables before it takes an item.
// Depends on ssbfs_pkg, ssbfs_store, ssbfs_mac and ssbfs_seq.
module stereo_six_band_fir_splitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [ssbfs_pkg::SW-1:0]     cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [ssbfs_pkg::SW-1:0]     left_sample_i,
  input  logic [ssbfs_pkg::SW-1:0]     right_sample_i,
  input  logic [1:0]                   coef_table_i,
  input  logic [ssbfs_pkg::CIDX_W-1:0] coef_index_i,
  input  logic [ssbfs_pkg::SW-1:0]     coef_value_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ssbfs_pkg::SW-1:0]     gained_left_o,
  output logic [ssbfs_pkg::SW-1:0]     lowpass_left_o,
  output logic [ssbfs_pkg::SW-1:0]     highpass_left_o,
  output logic [ssbfs_pkg::SW-1:0]     bandpass_left_o,
  output logic [ssbfs_pkg::SW-1:0]     bandpass_right_o,
  output logic [ssbfs_pkg::SW-1:0]     highpass_right_o,
  output logic [ssbfs_pkg::SW-1:0]     lowpass_right_o
);
  import ssbfs_pkg::*;

  logic [SW-1:0] pre_gain_q;
  logic [SW-1:0] left_q, right_q;
  logic [SW-1:0] res_q [8];
  logic          in_accept;
  logic          out_free;
  logic          load;
  op_t           iss_op, op_q;
  mem_req_t      req;
  res_t          mac_res;
  logic [SW-1:0] dl_rdata, cf_rdata;
  logic [SW-1:0] opa, opb, x_op;
  logic          out_valid_q;
  logic [SW-1:0] gl_q, lpl_q, hpl_q, bpl_q, bpr_q, hpr_q, lpr_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Pre-gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_gain_q <= SMAX_V;
    end else if (cfg_we_i) begin
      pre_gain_q <= cfg_wdata_i;
    end
  end

  // Hold the accepted sample pair
  always_ff @(posedge clk_i) begin
    if (in_accept && cmd_i == CMD_SAMPLE) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
    end
  end

  ssbfs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .cmd_i        (cmd_i),
    .coef_table_i (coef_table_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .gl_i         (res_q[SLOT_GL]),
    .gr_i         (res_q[SLOT_GR]),
    .res_i        (mac_res),
    .out_free_i   (out_free),
    .in_stall_o   (in_stall_o),
    .op_o         (iss_op),
    .req_o        (req),
    .load_o       (load)
  );

  ssbfs_store u_store (
    .clk_i      (clk_i),
    .req_i      (req),
    .dl_rdata_o (dl_rdata),
    .cf_rdata_o (cf_rdata)
  );

  // Delay the op tag to line up with the registered memory reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= iss_op;
    end
  end

  // Select MAC operands: gain step or filter tap
  assign x_op = (op_q.slot <= SLOT_BPL) ? res_q[SLOT_GL] : res_q[SLOT_GR];
  always_comb begin
    if (op_q.gain) begin
      opa = pre_gain_q;
      opb = (op_q.slot == SLOT_GR) ? right_q : left_q;
    end else begin
      opa = cf_rdata;
      opb = op_q.bypass ? x_op : dl_rdata;
    end
  end

  ssbfs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_q),
    .a_i    (opa),
    .b_i    (opb),
    .res_o  (mac_res)
  );

  // Collect finished sums by slot
  always_ff @(posedge clk_i) begin
    if (mac_res.valid) begin
      res_q[mac_res.slot] <= mac_res.data;
    end
  end

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      gl_q  <= res_q[SLOT_GL];
      lpl_q <= res_q[SLOT_LPL];
      hpl_q <= res_q[SLOT_HPL];
      bpl_q <= res_q[SLOT_BPL];
      bpr_q <= res_q[SLOT_BPR];
      hpr_q <= res_q[SLOT_HPR];
      lpr_q <= res_q[SLOT_LPR];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gained_left_o    = gl_q;
  assign lowpass_left_o   = lpl_q;
  assign highpass_left_o  = hpl_q;
  assign bandpass_left_o  = bpl_q;
  assign bandpass_right_o = bpr_q;
  assign highpass_right_o = hpr_q;
  assign lowpass_right_o  = lpr_q;

endmodule

// File: rtl/ssbfs_store.sv
// Delay-line and coefficient memories, one write and one registered read each.
// Depends on ssbfs_pkg for sizes and the request struct.
module ssbfs_store (
  input  logic                       clk_i,
  input  ssbfs_pkg::mem_req_t        req_i,
  output logic [ssbfs_pkg::SW-1:0]   dl_rdata_o,
  output logic [ssbfs_pkg::SW-1:0]   cf_rdata_o
);
  import ssbfs_pkg::*;

  logic [SW-1:0] dl_mem [DL_DEPTH];
  logic [SW-1:0] cf_mem [CF_DEPTH];
  logic [SW-1:0] dl_rdata_q;
  logic [SW-1:0] cf_rdata_q;

  // Delay lines of all six filters
  always_ff @(posedge clk_i) begin
    if (req_i.dl_we) begin
      dl_mem[req_i.dl_waddr] <= req_i.dl_wdata;
    end
    dl_rdata_q <= dl_mem[req_i.dl_raddr];
  end

  // Three coefficient tables
  always_ff @(posedge clk_i) begin
    if (req_i.cf_we) begin
      cf_mem[req_i.cf_waddr] <= req_i.cf_wdata;
    end
    cf_rdata_q <= cf_mem[req_i.cf_raddr];
  end

  assign dl_rdata_o = dl_rdata_q;
  assign cf_rdata_o = cf_rdata_q;

endmodule

// File: rtl/ssbfs_mac.sv
// Shared multiply, scale, saturate and accumulate unit, two register stages.
// Depends on ssbfs_pkg for widths, saturation limits and the op/result structs.
module ssbfs_mac (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssbfs_pkg::op_t           op_i,
  input  logic [ssbfs_pkg::SW-1:0] a_i,
  input  logic [ssbfs_pkg::SW-1:0] b_i,
  output ssbfs_pkg::res_t          res_o
);
  import ssbfs_pkg::*;

  op_t                op1_q, op2_q;
  logic [PW-1:0]      prod_q;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PW-1:0]      shifted;
  logic [SW-1:0]      term;
  logic [ACC_W-1:0]   acc_base;
  logic [ACC_W:0]     sum;
  logic [SW-1:0]      out_sat;

  // Stage one: exact product
  always_ff @(posedge clk_i) begin
    prod_q <= PW'($signed(a_i) * $signed(b_i));
  end

  // Scale the product back to Q1.(SW-1), rounding toward minus infinity
  assign shifted = PW'($signed(prod_q) >>> FRAC);

  // Saturate the term; only minus one squared overflows
  always_comb begin
    if (shifted[SW] != shifted[SW-1]) begin
      term = shifted[SW] ? SMIN_V : SMAX_V;
    end else begin
      term = shifted[SW-1:0];
    end
  end

  // Stage two: accumulate with saturation to the accumulator range
  assign acc_base = op1_q.first ? '0 : acc_q;
  assign sum = {acc_base[ACC_W-1], acc_base} + {{(ACC_W+1-SW){term[SW-1]}}, term};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op1_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // Advance the op tags alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
      op2_q <= '0;
    end else begin
      op1_q <= op_i;
      op2_q <= op1_q;
    end
  end

  // Saturate the finished sum to the sample range
  always_comb begin
    if ((&acc_q[ACC_W-1:SW-1]) || !(|acc_q[ACC_W-1:SW-1])) begin
      out_sat = acc_q[SW-1:0];
    end else begin
      out_sat = acc_q[ACC_W-1] ? SMIN_V : SMAX_V;
    end
  end

  assign res_o.valid = op2_q.valid && op2_q.last;
  assign res_o.slot  = op2_q.slot;
  assign res_o.data  = out_sat;

endmodule

// File: rtl/ssbfs_seq.sv
// Sequencer: memory clearing pass, coefficient writes, gain and tap issue, output load.
// Depends on ssbfs_pkg for sizes, codes, structs and address helpers.
module ssbfs_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_accept_i,
  input  logic                         cmd_i,
  input  logic [1:0]                   coef_table_i,
  input  logic [ssbfs_pkg::CIDX_W-1:0] coef_index_i,
  input  logic [ssbfs_pkg::SW-1:0]     coef_value_i,
  input  logic [ssbfs_pkg::SW-1:0]     gl_i,
  input  logic [ssbfs_pkg::SW-1:0]     gr_i,
  input  ssbfs_pkg::res_t              res_i,
  input  logic                         out_free_i,
  output logic                         in_stall_o,
  output ssbfs_pkg::op_t               op_o,
  output ssbfs_pkg::mem_req_t          req_o,
  output logic                         load_o
);
  import ssbfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_GAINL = 3'd2;
  localparam logic [2:0] S_GAINR = 3'd3;
  localparam logic [2:0] S_GWAIT = 3'd4;
  localparam logic [2:0] S_FILT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       st_q, st_d;
  logic [DL_AW-1:0] cnt_q, cnt_d;
  logic [2:0]       f_q, f_d;
  logic [TAP_W-1:0] k_q, k_d;
  logic [TAP_W-1:0] idx_q, idx_d;
  logic [TAP_W-1:0] pos_q, pos_d;
  logic [SW-1:0]    x;
  logic             coef_ok;

  assign x       = (f_q < 3'd3) ? gl_i : gr_i;
  assign coef_ok = (coef_table_i <= TBL_BP) && (32'(coef_index_i) < TAPS);

  // Next state and issue
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    f_d    = f_q;
    k_d    = k_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    op_o   = '0;
    req_o  = '0;
    load_o = 1'b0;
    case (st_q)
      S_CLEAR: begin
        req_o.dl_we    = 1'b1;
        req_o.dl_waddr = cnt_q;
        if (cnt_q < DL_AW'(CF_DEPTH)) begin
          req_o.cf_we    = 1'b1;
          req_o.cf_waddr = cnt_q[CF_AW-1:0];
        end
        if (cnt_q == DL_AW'(DL_DEPTH - 1)) begin
          st_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept_i) begin
          if (cmd_i == CMD_COEF) begin
            req_o.cf_we    = coef_ok;
            req_o.cf_waddr = cf_addr(coef_table_i, TAP_W'(coef_index_i));
            req_o.cf_wdata = coef_value_i;
          end else begin
            st_d = S_GAINL;
          end
        end
      end
      S_GAINL: begin
        op_o = '{valid: 1'b1, first: 1'b1, last: 1'b1, bypass: 1'b0,
                 gain: 1'b1, slot: SLOT_GL};
        st_d = S_GAINR;
      end
      S_GAINR: begin
        op_o = '{valid: 1'b1, first: 1'b1, last: 1'b1, bypass: 1'b0,
                 gain: 1'b1, slot: SLOT_GR};
        st_d = S_GWAIT;
      end
      S_GWAIT: begin
        if (res_i.valid && res_i.slot == SLOT_GR) begin
          st_d  = S_FILT;
          f_d   = '0;
          k_d   = '0;
          idx_d = pos_q;
        end
      end
      S_FILT: begin
        op_o.valid     = 1'b1;
        op_o.first     = (k_q == '0);
        op_o.last      = (k_q == TAP_W'(TAPS - 1));
        op_o.bypass    = (k_q == '0);
        op_o.slot      = f_q + 3'd1;
        req_o.dl_raddr = dl_addr(f_q, idx_q);
        req_o.cf_raddr = cf_addr(filt_table(f_q), k_q);
        // store the newest gained sample as its first tap is issued
        req_o.dl_we    = (k_q == '0);
        req_o.dl_waddr = dl_addr(f_q, pos_q);
        req_o.dl_wdata = x;
        idx_d = (idx_q == '0) ? TAP_W'(TAPS - 1) : idx_q - 1'b1;
        if (k_q == TAP_W'(TAPS - 1)) begin
          k_d   = '0;
          idx_d = pos_q;
          if (f_q == 3'(NFILT - 1)) begin
            st_d  = S_DRAIN;
            pos_d = (pos_q == TAP_W'(TAPS - 1)) ? '0 : pos_q + 1'b1;
          end else begin
            f_d = f_q + 3'd1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (res_i.valid && res_i.slot == SLOT_LPR) begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          load_o = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLEAR;
      cnt_q <= '0;
      f_q   <= '0;
      k_q   <= '0;
      idx_q <= '0;
      pos_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      f_q   <= f_d;
      k_q   <= k_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
    end
  end

  assign in_stall_o = (st_q != S_IDLE);

  // Results only come back while a sample item is in flight
  a_res_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> (st_q == S_GWAIT || st_q == S_FILT || st_q == S_DRAIN))
    else $error("accumulate result outside a sample item");

  // Each filter starts its tap walk at the write position
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FILT && k_q == '0) |-> (idx_q == pos_q))
    else $error("tap walk does not start at the write position");

  // The output register is loaded only when it is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |-> out_free_i)
    else $error("output register overwritten while held");

  // Write position advances once per sample item, and only at the end of the tap walk
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != $past(pos_q)) |-> ($past(st_q) == S_FILT && st_q == S_DRAIN))
    else $error("write position moved outside the end of the tap walk");

endmodule
